FILE: hdl/toeq_pkg.sv
// Package: shared types, constants and codes for the timestamp ordered event queue.
`timescale 1ns / 1ps
package toeq_pkg;
   localparam int Depth = 16;
   localparam int HandleBits = 8;
   localparam int IdxBits = $clog2(Depth);
   localparam int CntBits = $clog2(Depth + 1);

   typedef enum logic [1:0] {
      MODE_ENQ   = 2'd0,
      MODE_DEQ   = 2'd1,
      MODE_COUNT = 2'd2,
      MODE_CLEAR = 2'd3
   } mode_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [62:0] stamp_in;
      logic [62:0] now_time;
      logic [31:0] type_code;
      logic        match_any;
      logic [7:0]  handle_in;
   } req_type;

   typedef struct packed {
      logic        full_error;
      logic        found;
      logic [7:0]  handle_out;
      logic [62:0] stamp_out;
      logic [31:0] type_out;
      logic        more_left;
      logic [4:0]  total_count;
      logic [4:0]  match_count;
      logic [62:0] oldest_stamp;
      logic        empty_res;
   } rsp_type;

   typedef struct packed {
      logic [62:0]           stamp;
      logic [31:0]           kind;
      logic [HandleBits-1:0] handle;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REPLY
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic exec;
      logic reply;
   } cmd_type;
endpackage

FILE: hdl/toeq_datapath.sv
// Datapath: shift-register cell chain with per-cell compare, insert and remove.
`timescale 1ns / 1ps
module toeq_datapath import toeq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  req_type req_data,
   output rsp_type rsp_data
);
   entry_type             cell_ff [Depth];
   entry_type             cell_in [Depth];
   entry_type             cell_prev [Depth];
   entry_type             cell_next [Depth];
   logic [CntBits-1:0]    occ_ff, occ_in;
   req_type               req_ff;
   rsp_type               rsp_ff, rsp_in;
   logic [62:0]           eff;
   logic [Depth-1:0]      later, later_prev, hit, first;
   logic [IdxBits-1:0]    pos;
   logic                  any_hit;
   logic                  seen;
   logic [CntBits-1:0]    mcnt;
   logic                  full;
   entry_type             newe, sel;

   assign eff  = (req_ff.stamp_in != '0) ? req_ff.stamp_in : req_ff.now_time;
   assign full = (occ_ff >= CntBits'(Depth));
   assign newe = '{stamp: eff, kind: req_ff.type_code,
                   handle: req_ff.handle_in[HandleBits-1:0]};

   always_comb begin
      seen = 1'b0;
      for (int i = 0; i < Depth; i++) begin
         later[i] = (CntBits'(i) < occ_ff) && (cell_ff[i].stamp > eff);
         hit[i]   = (CntBits'(i) < occ_ff)
                    && (req_ff.match_any || cell_ff[i].kind == req_ff.type_code);
         first[i] = hit[i] && !seen;
         seen     = seen | hit[i];
      end
      any_hit = |hit;
      mcnt = '0;
      pos = '0;
      sel = '0;
      for (int i = 0; i < Depth; i++) begin
         mcnt = mcnt + CntBits'(hit[i]);
         if (first[i]) begin
            pos = IdxBits'(i);
            sel = cell_ff[i];
         end
      end
   end

   // Neighbor views of the chain; the ends take the new entry or hold.
   always_comb begin
      cell_prev[0]  = newe;
      later_prev[0] = 1'b0;
      for (int i = 1; i < Depth; i++) begin
         cell_prev[i]  = cell_ff[i-1];
         later_prev[i] = later[i-1];
      end
      cell_next[Depth-1] = cell_ff[Depth-1];
      for (int i = 0; i < Depth - 1; i++) begin
         cell_next[i] = cell_ff[i+1];
      end
   end

   // Per-cell next value: shift right behind the insert point, left behind the hit.
   always_comb begin
      for (int i = 0; i < Depth; i++) begin
         cell_in[i] = cell_ff[i];
         if (cmd.exec && req_ff.mode == MODE_ENQ && !full) begin
            if (later[i]) cell_in[i] = later_prev[i] ? cell_prev[i] : newe;
            else if (CntBits'(i) == occ_ff) begin
               cell_in[i] = later_prev[i] ? cell_prev[i] : newe;
            end
         end else if (cmd.exec && req_ff.mode == MODE_DEQ && any_hit) begin
            if (IdxBits'(i) >= pos) cell_in[i] = cell_next[i];
         end
      end
   end

   always_comb begin
      occ_in = occ_ff;
      if (cmd.exec) begin
         unique case (mode_type'(req_ff.mode))
            MODE_ENQ:   if (!full) occ_in = occ_ff + 1'b1;
            MODE_DEQ:   if (any_hit) occ_in = occ_ff - 1'b1;
            MODE_COUNT: occ_in = occ_ff;
            MODE_CLEAR: occ_in = '0;
            default:    occ_in = occ_ff;
         endcase
      end
   end

   // Result fields that depend on the pre-operation contents.
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.exec) begin
         rsp_in = '0;
         unique case (mode_type'(req_ff.mode))
            MODE_ENQ: begin
               rsp_in.stamp_out  = eff;
               rsp_in.full_error = full;
            end
            MODE_DEQ: if (any_hit) begin
               rsp_in.found      = 1'b1;
               rsp_in.handle_out = 8'(sel.handle);
               rsp_in.stamp_out  = sel.stamp;
               rsp_in.type_out   = sel.kind;
            end
            MODE_COUNT: rsp_in.match_count = 5'(mcnt);
            MODE_CLEAR: rsp_in = '0;
            default:    rsp_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
      rsp_ff <= rsp_in;
      cell_ff <= cell_in;
      if (reset) occ_ff <= '0;
      else occ_ff <= occ_in;
   end

   // Queue status comes from the updated contents.
   always_comb begin
      rsp_data = rsp_ff;
      rsp_data.more_left    = (occ_ff != '0);
      rsp_data.total_count  = 5'(occ_ff);
      rsp_data.oldest_stamp = (occ_ff != '0) ? cell_ff[0].stamp : '1;
      rsp_data.empty_res    = (occ_ff == '0);
   end
endmodule

FILE: hdl/toeq_control.sv
// Controller: sequences load, execute and reply for one transfer.
`timescale 1ns / 1ps
module toeq_control import toeq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output cmd_type cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            cmd.load = start;
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            busy = 1'b0;
            cmd.reply = 1'b1;
            cmd.load = start;
            state_in = start ? ST_EXEC : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

FILE: hdl/timestamp_ordered_event_queue_unit.sv
// Top level: timestamp ordered event queue, controller plus cell-chain datapath.
`timescale 1ns / 1ps
// Issue a command by raising start while busy is low; the transfer happens at that
// edge. The queue is a 16-cell shift chain: every cell compares its stamp or type in
// parallel, then the chain shifts at the execute edge. Each command is loaded, then
// executed, then rsp_valid pulses for one cycle with the result, and a new command
// may be started in that same cycle. The receiver cannot stall: take the result in
// the cycle rsp_valid is high. Storage needs no clearing pass after reset.
module timestamp_ordered_event_queue_unit import toeq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);
   cmd_type cmd;

   toeq_control u_control (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   toeq_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   // Strobe the result in the reply cycle.
   assign rsp_valid = cmd.reply;
endmodule
